### rtl/assert_macros.svh
// assertion macros shared by the stream access-unit assembler rtl
// expects signals clk and rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, checked outside reset
`define SAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### rtl/sau_pkg.sv
// types and constants of the stream access-unit assembler
// no dependencies

package sau_pkg;

    // width of the running unit length and of the statistics counters
    localparam int LEN_BITS   = 24;
    localparam int COUNT_BITS = 32;

    // limit register holds 24 bits, limit arithmetic wide enough for both
    localparam int LIM_W = (LEN_BITS > 24) ? LEN_BITS : 24;
    localparam int SUM_W = LIM_W + 1;

    localparam logic [23:0] MAX_BYTES_RESET = 24'd1048576;
    localparam logic [7:0]  GAP_LIMIT       = 8'd128;

    // result status codes
    localparam logic [1:0] ST_MORE      = 2'd0;
    localparam logic [1:0] ST_READY     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // statistics counter slots
    localparam int CNT_PACKETS   = 0;
    localparam int CNT_BYTES     = 1;
    localparam int CNT_MALFORMED = 2;
    localparam int CNT_DROPPED   = 3;
    localparam int CNT_COMPLETED = 4;
    localparam int CNT_LOST      = 5;
    localparam int CNT_REORDER   = 6;
    localparam int NUM_CNT       = 7;

    typedef struct packed {
        logic               payload_present;
        logic [63:0]        stream_ident;
        logic [47:0]        source_address;
        logic [7:0]         seq_number;
        logic [15:0]        payload_length;
        logic               end_marker;
        logic [31:0]        media_time;
        logic               media_time_valid;
        logic signed [63:0] capture_time;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [23:0]        unit_length;
        logic [31:0]        unit_media_time;
        logic               unit_media_time_valid;
        logic signed [63:0] unit_capture_time;
        logic [31:0]        packet_count;
        logic [31:0]        byte_count;
        logic [31:0]        malformed_count;
        logic [31:0]        dropped_unit_count;
        logic [31:0]        completed_unit_count;
        logic [31:0]        lost_count;
        logic [31:0]        reorder_count;
    } result_t;

endpackage

### rtl/sau_ifs.sv
// valid/ready channel interfaces of the stream access-unit assembler
// depends on sau_pkg

interface sau_item_if;
    logic           valid;
    logic           ready;
    sau_pkg::item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface sau_result_if;
    logic             valid;
    logic             ready;
    sau_pkg::result_t res;

    modport source (output valid, output res, input ready);
    modport sink   (input valid, input res, output ready);
endinterface

interface sau_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] max_unit_bytes;

    modport source (output valid, output max_unit_bytes, input ready);
    modport sink   (input valid, input max_unit_bytes, output ready);
endinterface

### rtl/sau_in_stage.sv
// input register of the assembler: holds one packet beat for the core
// depends on sau_pkg and sau_ifs

module sau_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    sau_item_if.sink        packet,
    input  logic            take,
    output logic            valid,
    output sau_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    sau_pkg::item_t item_reg;
    logic           load;

    assign packet.ready = !valid_reg || take;
    assign load         = packet.valid && packet.ready;
    assign valid_next   = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= packet.item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

### rtl/sau_core.sv
// tracking core: stream, sequence and unit length state, statistics counters
// and the size-limit register; depends on sau_pkg, sau_ifs, assert_macros.svh

`include "assert_macros.svh"

module sau_core (
    input  logic              clk,
    input  logic              rst_n,
    sau_cfg_if.sink           cfg,
    input  logic              fire,
    input  sau_pkg::item_t    item,
    output sau_pkg::result_t  result
);

    logic [23:0]                   max_bytes_reg;
    logic                          stream_known_reg, stream_known_next;
    logic [63:0]                   cur_stream_reg, cur_stream_next;
    logic [47:0]                   cur_source_reg, cur_source_next;
    logic                          seq_known_reg, seq_known_next;
    logic [7:0]                    next_seq_reg, next_seq_next;
    logic [sau_pkg::LEN_BITS-1:0]  partial_reg, partial_next;
    logic [sau_pkg::COUNT_BITS-1:0] cnt_reg  [sau_pkg::NUM_CNT];
    logic [sau_pkg::COUNT_BITS-1:0] cnt_next [sau_pkg::NUM_CNT];

    logic [sau_pkg::LIM_W-1:0]     lim_raw;
    logic [sau_pkg::LIM_W-1:0]     lim_cap;
    logic [sau_pkg::LIM_W-1:0]     limit;
    logic                          no_payload;
    logic                          new_stream;
    logic [sau_pkg::LEN_BITS-1:0]  part_base;
    logic [sau_pkg::SUM_W-1:0]     sum;
    logic                          over;
    logic [7:0]                    gap;

    assign cfg.ready = 1'b1;

    // effective limit: zero acts as one, capped to what the length holds
    assign lim_cap = {sau_pkg::LIM_W{1'b1}} >> (sau_pkg::LIM_W - sau_pkg::LEN_BITS);
    assign lim_raw = (max_bytes_reg == 24'd0) ? sau_pkg::LIM_W'(1)
                                              : sau_pkg::LIM_W'(max_bytes_reg);
    assign limit   = (lim_raw > lim_cap) ? lim_cap : lim_raw;

    assign no_payload = !item.payload_present || (item.payload_length == 16'd0);
    assign new_stream = !stream_known_reg || (item.stream_ident != cur_stream_reg)
                        || (item.source_address != cur_source_reg);
    assign part_base  = new_stream ? '0 : partial_reg;
    assign sum        = sau_pkg::SUM_W'(part_base) + sau_pkg::SUM_W'(item.payload_length);
    assign over       = sum > sau_pkg::SUM_W'(limit);
    assign gap        = item.seq_number - next_seq_reg;

    always_comb
    begin
        stream_known_next = stream_known_reg;
        cur_stream_next   = cur_stream_reg;
        cur_source_next   = cur_source_reg;
        seq_known_next    = seq_known_reg;
        next_seq_next     = next_seq_reg;
        partial_next      = partial_reg;
        for (int i = 0; i < sau_pkg::NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        result = '0;

        cnt_next[sau_pkg::CNT_PACKETS] = cnt_reg[sau_pkg::CNT_PACKETS] + 1'b1;
        cnt_next[sau_pkg::CNT_BYTES]   = cnt_reg[sau_pkg::CNT_BYTES]
                                         + sau_pkg::COUNT_BITS'(item.payload_length);

        if (no_payload)
        begin
            cnt_next[sau_pkg::CNT_MALFORMED] = cnt_reg[sau_pkg::CNT_MALFORMED] + 1'b1;
            result.status = sau_pkg::ST_MALFORMED;
        end
        else
        begin
            // stream change drops whatever was being built
            if (new_stream)
            begin
                if (stream_known_reg && (partial_reg != '0))
                begin
                    cnt_next[sau_pkg::CNT_DROPPED] = cnt_reg[sau_pkg::CNT_DROPPED] + 1'b1;
                end
                stream_known_next = 1'b1;
                cur_stream_next   = item.stream_ident;
                cur_source_next   = item.source_address;
            end

            if (!new_stream && seq_known_reg && (item.seq_number != next_seq_reg))
            begin
                if (gap < sau_pkg::GAP_LIMIT)
                begin
                    cnt_next[sau_pkg::CNT_LOST] = cnt_reg[sau_pkg::CNT_LOST]
                                                  + sau_pkg::COUNT_BITS'(gap);
                end
                else
                begin
                    cnt_next[sau_pkg::CNT_REORDER] = cnt_reg[sau_pkg::CNT_REORDER] + 1'b1;
                end
            end
            next_seq_next  = item.seq_number + 8'd1;
            seq_known_next = 1'b1;

            if (over)
            begin
                // after a stream change part_base is zero, so dropped bumps once at most
                if (part_base != '0)
                begin
                    cnt_next[sau_pkg::CNT_DROPPED] = cnt_reg[sau_pkg::CNT_DROPPED] + 1'b1;
                end
                partial_next = '0;
                cnt_next[sau_pkg::CNT_MALFORMED] = cnt_reg[sau_pkg::CNT_MALFORMED] + 1'b1;
                result.status = sau_pkg::ST_MALFORMED;
            end
            else if (item.end_marker)
            begin
                result.status                = sau_pkg::ST_READY;
                result.unit_length           = 24'(sum);
                result.unit_media_time       = item.media_time;
                result.unit_media_time_valid = item.media_time_valid;
                result.unit_capture_time     = item.capture_time;
                cnt_next[sau_pkg::CNT_COMPLETED] = cnt_reg[sau_pkg::CNT_COMPLETED] + 1'b1;
                partial_next = '0;
            end
            else
            begin
                partial_next = sau_pkg::LEN_BITS'(sum);
            end
        end

        result.packet_count         = 32'(cnt_next[sau_pkg::CNT_PACKETS]);
        result.byte_count           = 32'(cnt_next[sau_pkg::CNT_BYTES]);
        result.malformed_count      = 32'(cnt_next[sau_pkg::CNT_MALFORMED]);
        result.dropped_unit_count   = 32'(cnt_next[sau_pkg::CNT_DROPPED]);
        result.completed_unit_count = 32'(cnt_next[sau_pkg::CNT_COMPLETED]);
        result.lost_count           = 32'(cnt_next[sau_pkg::CNT_LOST]);
        result.reorder_count        = 32'(cnt_next[sau_pkg::CNT_REORDER]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg    <= sau_pkg::MAX_BYTES_RESET;
            stream_known_reg <= 1'b0;
            cur_stream_reg   <= '0;
            cur_source_reg   <= '0;
            seq_known_reg    <= 1'b0;
            next_seq_reg     <= '0;
            partial_reg      <= '0;
            for (int i = 0; i < sau_pkg::NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                max_bytes_reg <= cfg.max_unit_bytes;
            end
            if (fire)
            begin
                stream_known_reg <= stream_known_next;
                cur_stream_reg   <= cur_stream_next;
                cur_source_reg   <= cur_source_next;
                seq_known_reg    <= seq_known_next;
                next_seq_reg     <= next_seq_next;
                partial_reg      <= partial_next;
                for (int i = 0; i < sau_pkg::NUM_CNT; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    end

    `SAU_ASSERT_NXT(a_ready_clears_unit, fire && (result.status == sau_pkg::ST_READY), partial_reg == '0)
    `SAU_ASSERT_IMP(a_unit_fields_quiet, fire && (result.status != sau_pkg::ST_READY), (result.unit_length == 24'd0) && !result.unit_media_time_valid)
    `SAU_ASSERT_NXT(a_packet_count_steps, fire, cnt_reg[sau_pkg::CNT_PACKETS] == $past(cnt_reg[sau_pkg::CNT_PACKETS]) + 1'b1)

endmodule

### rtl/sau_out_stage.sv
// result register of the assembler: holds one result beat until taken
// depends on sau_pkg and sau_ifs

module sau_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sau_pkg::result_t  res,
    output logic              free,
    sau_result_if.source      result
);

    logic             valid_reg;
    logic             valid_next;
    sau_pkg::result_t res_reg;

    assign free       = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid = valid_reg;
    assign result.res   = res_reg;

endmodule

### rtl/stream_access_unit_assembler_top.sv
// top level of the stream access-unit assembler
// depends on sau_pkg, sau_ifs, sau_in_stage, sau_core, sau_out_stage, assert_macros.svh

// Tracks packet descriptors of a media stream and reports, for every packet
// beat, one result beat: need more, unit ready (with the unit length and the
// timestamps of the completing packet) or malformed, plus seven statistics
// counters as they stand after that packet. A packet beat is registered on
// acceptance in the input register, is evaluated against the stream, sequence
// and length state once the result register has room, and its result is then
// registered there and offered as the result beat. One packet beat is accepted
// every cycle as long as results are taken; the rate is set by the state update
// in the core, whose next state is combinational. If the result is not
// taken, the result register and the input register each hold one beat and
// the packet channel then stalls. The size limit is written through the
// configuration channel (always ready) and must only be changed while no
// packet is in flight. There is no clearing pass after reset.

`include "assert_macros.svh"

module stream_access_unit_assembler_top (
    input  logic          clk,
    input  logic          rst_n,
    sau_item_if.sink      packet,
    sau_result_if.source  result,
    sau_cfg_if.sink       cfg
);

    // input register outputs
    logic             in_valid;
    sau_pkg::item_t   in_item;

    // result register has room when empty or being drained this cycle
    logic             out_free;

    // core evaluates the held packet when the result can be stored
    logic             take;
    sau_pkg::result_t core_res;

    assign take = in_valid && out_free;

    sau_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (packet),
        .take   (take),
        .valid  (in_valid),
        .item   (in_item)
    );

    sau_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (take),
        .item   (in_item),
        .result (core_res)
    );

    sau_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take),
        .res    (core_res),
        .free   (out_free),
        .result (result)
    );

    // packet side stalls only with both registers full and the result held
    `SAU_ASSERT_IMP(a_stall_only_when_full, !packet.ready, in_valid && result.valid && !result.ready)
    // an evaluated packet always shows up as a result beat next cycle
    `SAU_ASSERT_NXT(a_take_gives_result, take, result.valid)

endmodule
